// File: hw/rtl/cmpc_pkg.sv
// shared types and constants for the clipped midpoint circle plotter
`timescale 1ns / 1ps
`default_nettype none

package cmpc_pkg;

  localparam int QUEUE_DEPTH_DEF = 2;

  localparam logic KIND_START = 1'b0;
  localparam logic KIND_STEP  = 1'b1;

  localparam logic [2:0] REG_SURFACE_WIDTH  = 3'd0;
  localparam logic [2:0] REG_SURFACE_HEIGHT = 3'd1;
  localparam logic [2:0] REG_CLIP_LEFT      = 3'd2;
  localparam logic [2:0] REG_CLIP_TOP       = 3'd3;
  localparam logic [2:0] REG_CLIP_RIGHT     = 3'd4;
  localparam logic [2:0] REG_CLIP_BOTTOM    = 3'd5;
  localparam logic [2:0] REG_ROW_STRIDE     = 3'd6;
  localparam logic [2:0] REG_BYTES_PER_PIX  = 3'd7;

  localparam logic [1:0] BPP_DRAWN = 2'd1;

  typedef struct packed {
    logic [14:0] surface_width;
    logic [14:0] surface_height;
    logic [15:0] clip_left;
    logic [15:0] clip_top;
    logic [15:0] clip_right;
    logic [15:0] clip_bottom;
    logic [14:0] row_stride;
    logic [1:0]  bytes_per_pixel;
  } cmpc_cfg_t;

  // one request from the front: four plots, or a single empty result
  typedef struct packed {
    logic        empty;
    logic        done;
    logic [15:0] centre_col;
    logic [15:0] centre_row;
    logic [15:0] offset_x;
    logic [15:0] offset_r;
    logic [7:0]  color;
  } cmpc_desc_t;

endpackage

`default_nettype wire

// File: hw/rtl/cmpc_front.sv
// front end: accepts start and step requests and runs the circle decision state
`timescale 1ns / 1ps
`default_nettype none

module cmpc_front
  import cmpc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [55:0] s_axis_tdata,
  input  wire logic        s_axis_tuser,
  input  wire logic [1:0]  bytes_per_pixel,
  output logic             q_valid,
  input  wire logic        q_ready,
  output cmpc_desc_t       q_data
);

  logic [15:0] offset_x, offset_r, twice_x, twice_r, decision_error;
  logic [15:0] centre_col, centre_row;
  logic [7:0]  latched_color;
  logic        figure_active;

  logic [15:0] offset_x_next, offset_r_next, twice_x_next, twice_r_next;
  logic [15:0] decision_error_next, centre_col_next, centre_row_next;
  logic [7:0]  latched_color_next;
  logic        figure_active_next;

  logic [15:0] in_cx, in_cy, in_rad;
  logic [7:0]  in_color;
  logic [15:0] t_h, t_v, x_inc, r_dec, tx_inc, tr_dec;
  logic        go_h, go_v, accept;

  assign in_cx    = s_axis_tdata[15:0];
  assign in_cy    = s_axis_tdata[31:16];
  assign in_rad   = s_axis_tdata[47:32];
  assign in_color = s_axis_tdata[55:48];

  assign s_axis_tready = q_ready;
  assign accept        = s_axis_tvalid && q_ready;
  assign q_valid       = s_axis_tvalid;

  always_comb begin
    t_h    = ((decision_error + offset_r) << 1) - 16'd1;
    t_v    = ((decision_error - offset_x) << 1) - 16'd1;
    go_v   = !decision_error[15] && decision_error != 16'd0 && !(t_v[15] || t_v == 16'd0);
    go_h   = decision_error[15] && (t_h[15] || t_h == 16'd0);
    x_inc  = offset_x + 16'd1;
    r_dec  = offset_r - 16'd1;
    tx_inc = twice_x + 16'd2;
    tr_dec = twice_r - 16'd2;

    offset_x_next       = offset_x;
    offset_r_next       = offset_r;
    twice_x_next        = twice_x;
    twice_r_next        = twice_r;
    decision_error_next = decision_error;
    centre_col_next     = centre_col;
    centre_row_next     = centre_row;
    latched_color_next  = latched_color;
    figure_active_next  = figure_active;

    q_data            = '0;
    q_data.empty      = 1'b1;
    q_data.done       = 1'b1;

    if (s_axis_tuser == KIND_START) begin
      if (bytes_per_pixel != BPP_DRAWN || in_rad[15]) begin
        figure_active_next = 1'b0;
      end else begin
        centre_col_next     = in_cx;
        centre_row_next     = in_cy;
        latched_color_next  = in_color;
        offset_x_next       = '0;
        offset_r_next       = in_rad;
        twice_x_next        = '0;
        twice_r_next        = in_rad << 1;
        decision_error_next = 16'd2 - (in_rad << 1);
        figure_active_next  = 1'b1;
        q_data.empty        = 1'b0;
        q_data.done         = 1'b0;
      end
    end else if (figure_active) begin
      if (go_h) begin
        offset_x_next       = x_inc;
        twice_x_next        = tx_inc;
        decision_error_next = decision_error + 16'd1 + tx_inc;
      end else if (go_v) begin
        offset_r_next       = r_dec;
        twice_r_next        = tr_dec;
        decision_error_next = decision_error + 16'd1 - tr_dec;
      end else begin
        offset_x_next       = x_inc;
        twice_x_next        = tx_inc;
        offset_r_next       = r_dec;
        twice_r_next        = tr_dec;
        decision_error_next = decision_error + 16'd2 + ((x_inc - r_dec) << 1);
      end
      figure_active_next = !offset_r_next[15];
      q_data.empty       = 1'b0;
      q_data.done        = offset_r_next[15];
    end

    q_data.centre_col = centre_col_next;
    q_data.centre_row = centre_row_next;
    q_data.offset_x   = offset_x_next;
    q_data.offset_r   = offset_r_next;
    q_data.color      = latched_color_next;
    if (q_data.empty) begin
      q_data.centre_col = '0;
      q_data.centre_row = '0;
      q_data.offset_x   = '0;
      q_data.offset_r   = '0;
      q_data.color      = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      offset_x       <= '0;
      offset_r       <= '0;
      twice_x        <= '0;
      twice_r        <= '0;
      decision_error <= '0;
      centre_col     <= '0;
      centre_row     <= '0;
      latched_color  <= '0;
      figure_active  <= 1'b0;
    end else if (accept) begin
      offset_x       <= offset_x_next;
      offset_r       <= offset_r_next;
      twice_x        <= twice_x_next;
      twice_r        <= twice_r_next;
      decision_error <= decision_error_next;
      centre_col     <= centre_col_next;
      centre_row     <= centre_row_next;
      latched_color  <= latched_color_next;
      figure_active  <= figure_active_next;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/cmpc_queue.sv
// short request queue between the front end and the plot stage
`timescale 1ns / 1ps
`default_nettype none

module cmpc_queue
  import cmpc_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_valid,
  output logic       in_ready,
  input  cmpc_desc_t in_data,
  output logic       out_valid,
  input  wire logic  out_ready,
  output cmpc_desc_t out_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmpc_desc_t       mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push, pop;

  assign in_ready  = count != CNT_W'(DEPTH);
  assign out_valid = count != '0;
  assign out_data  = mem[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/cmpc_back.sv
// plot stage: expands each request into plots, clips them and forms the byte offset
`timescale 1ns / 1ps
`default_nettype none

module cmpc_back
  import cmpc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  cmpc_cfg_t        cfg,
  input  wire logic        q_valid,
  output logic             q_ready,
  input  cmpc_desc_t       q_data,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [71:0]      m_axis_tdata,
  output logic [1:0]       m_axis_tuser,
  output logic             m_axis_tlast
);

  logic        en;
  logic [1:0]  idx;
  logic [16:0] px, py;
  logic [15:0] win_l, win_t, win_r, win_b;
  logic        vis, last;

  logic        s1_valid, s1_vis, s1_last, s1_done;
  logic [16:0] s1_px, s1_py;
  logic [7:0]  s1_color;

  logic        s2_valid, s2_vis, s2_last, s2_done;
  logic [16:0] s2_px, s2_py;
  logic [7:0]  s2_color;
  logic [29:0] s2_prod;

  logic [16:0] o_px, o_py;
  logic [29:0] o_offset;
  logic [7:0]  o_color;
  logic        o_vis, o_done;

  assign en      = !m_axis_tvalid || m_axis_tready;
  assign last    = q_data.empty || idx == 2'd3;
  assign q_ready = en && last;

  always_comb begin
    win_l = cfg.clip_left[15] ? 16'd0 : cfg.clip_left;
    win_t = cfg.clip_top[15] ? 16'd0 : cfg.clip_top;
    win_r = ($signed(cfg.clip_right) > $signed({1'b0, cfg.surface_width}))
            ? {1'b0, cfg.surface_width} : cfg.clip_right;
    win_b = ($signed(cfg.clip_bottom) > $signed({1'b0, cfg.surface_height}))
            ? {1'b0, cfg.surface_height} : cfg.clip_bottom;
    px = idx[1] ? {q_data.centre_col[15], q_data.centre_col} - {q_data.offset_x[15], q_data.offset_x}
                : {q_data.centre_col[15], q_data.centre_col} + {q_data.offset_x[15], q_data.offset_x};
    py = idx[0] ? {q_data.centre_row[15], q_data.centre_row} - {q_data.offset_r[15], q_data.offset_r}
                : {q_data.centre_row[15], q_data.centre_row} + {q_data.offset_r[15], q_data.offset_r};
    vis = $signed(px) >= $signed({win_l[15], win_l}) && $signed(px) < $signed({win_r[15], win_r})
       && $signed(py) >= $signed({win_t[15], win_t}) && $signed(py) < $signed({win_b[15], win_b});
    if (q_data.empty) begin
      px  = '0;
      py  = '0;
      vis = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_px    <= px;
      s1_py    <= py;
      s1_vis   <= vis;
      s1_color <= q_data.color;
      s1_last  <= last;
      s1_done  <= q_data.done;

      s2_px    <= s1_px;
      s2_py    <= s1_py;
      s2_vis   <= s1_vis;
      s2_color <= s1_color;
      s2_last  <= s1_last;
      s2_done  <= s1_done;
      s2_prod  <= {15'd0, s1_py[14:0]} * {15'd0, cfg.row_stride};

      o_px         <= s2_px;
      o_py         <= s2_py;
      o_vis        <= s2_vis;
      o_color      <= s2_color;
      o_done       <= s2_done;
      m_axis_tlast <= s2_last;
      o_offset     <= s2_vis ? s2_prod + {15'd0, s2_px[14:0]} : 30'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx           <= '0;
      s1_valid      <= 1'b0;
      s2_valid      <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else if (en) begin
      s1_valid      <= q_valid;
      s2_valid      <= s1_valid;
      m_axis_tvalid <= s2_valid;
      if (q_valid) begin
        idx <= last ? 2'd0 : idx + 2'd1;
      end
    end
  end

  assign m_axis_tdata = {o_color, o_offset, o_py, o_px};
  assign m_axis_tuser = {o_done, o_vis};

endmodule

`default_nettype wire

// File: hw/rtl/clipped_midpoint_circle_plotter_core.sv
// top level of the clipped midpoint circle plotter
`timescale 1ns / 1ps
`default_nettype none

// Draws circle outlines as a stream of pixel plots. A start request (tuser 0) latches
// centre, radius and colour and gives the four plots of the top and bottom points; each
// step request (tuser 1) makes one midpoint move and gives four more plots. The step that
// takes the radius term below zero sets figure_done on its plots and ends the circle. A
// negative radius, a pixel size other than one byte or a step with no circle active gives
// one empty result with figure_done set. Each plot carries visible (inside surface and
// clip window) and, when visible, the byte offset y*row_stride+x. A start or step request
// gives four plots, an empty request one; the plot stage gives one result per cycle while
// the output is not stalled; a small request queue lets the front end take new requests
// while plots are pending. Requests pass the queue, then the s1, s2 and o registers.
// Configuration writes take effect at once and must only be made while the block is idle.
module clipped_midpoint_circle_plotter_core
  import cmpc_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_wr_en,
  input  wire logic [2:0]  cfg_addr,
  input  wire logic [15:0] cfg_wdata,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [55:0] s_axis_tdata,  // center_x, center_y, radius, pen_color
  input  wire logic        s_axis_tuser,  // kind
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [71:0]      m_axis_tdata,  // pixel_x, pixel_y, pixel_offset, plot_color
  output logic [1:0]       m_axis_tuser,  // visible, figure_done
  output logic             m_axis_tlast   // last_of_step
);

  cmpc_cfg_t  cfg;
  cmpc_desc_t f_data, b_data;
  logic       f_valid, f_ready, b_valid, b_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.surface_width   <= 15'd640;
      cfg.surface_height  <= 15'd480;
      cfg.clip_left       <= 16'd0;
      cfg.clip_top        <= 16'd0;
      cfg.clip_right      <= 16'd32767;
      cfg.clip_bottom     <= 16'd32767;
      cfg.row_stride      <= 15'd640;
      cfg.bytes_per_pixel <= BPP_DRAWN;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        REG_SURFACE_WIDTH:  cfg.surface_width   <= cfg_wdata[14:0];
        REG_SURFACE_HEIGHT: cfg.surface_height  <= cfg_wdata[14:0];
        REG_CLIP_LEFT:      cfg.clip_left       <= cfg_wdata;
        REG_CLIP_TOP:       cfg.clip_top        <= cfg_wdata;
        REG_CLIP_RIGHT:     cfg.clip_right      <= cfg_wdata;
        REG_CLIP_BOTTOM:    cfg.clip_bottom     <= cfg_wdata;
        REG_ROW_STRIDE:     cfg.row_stride      <= cfg_wdata[14:0];
        REG_BYTES_PER_PIX:  cfg.bytes_per_pixel <= cfg_wdata[1:0];
        default: begin
        end
      endcase
    end
  end

  cmpc_front u_front (
    .clk             (clk),
    .rst             (rst),
    .s_axis_tvalid   (s_axis_tvalid),
    .s_axis_tready   (s_axis_tready),
    .s_axis_tdata    (s_axis_tdata),
    .s_axis_tuser    (s_axis_tuser),
    .bytes_per_pixel (cfg.bytes_per_pixel),
    .q_valid         (f_valid),
    .q_ready         (f_ready),
    .q_data          (f_data)
  );

  cmpc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_data   (f_data),
    .out_valid (b_valid),
    .out_ready (b_ready),
    .out_data  (b_data)
  );

  cmpc_back u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .q_valid       (b_valid),
    .q_ready       (b_ready),
    .q_data        (b_data),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

`default_nettype wire
